// ===== hdl/pasm_pkg.sv =====
// ----------------------------------------------------------------------------
// pasm_pkg
// Shared constants, codes and types of the polynomial add/sub/mul unit.
// ----------------------------------------------------------------------------
package pasm_pkg;

    localparam int MAX_DEGREE = 31;
    localparam int DEPTH      = MAX_DEGREE + 1;
    localparam int AW         = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    localparam int OP_W       = 2;
    localparam int IN_POW_W   = 5;
    localparam int COEF_W     = 16;
    localparam int DEG_W      = 5;
    localparam int MODE_W     = 2;
    localparam int POW_W      = 6;
    localparam int ACC_W      = 40;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_W      = 5;

    localparam logic [OP_W-1:0] OP_LOAD_A  = 2'd0;
    localparam logic [OP_W-1:0] OP_LOAD_B  = 2'd1;
    localparam logic [OP_W-1:0] OP_COMPUTE = 2'd2;

    localparam logic [MODE_W-1:0] MODE_ADD = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SUB = 2'd1;
    localparam logic [MODE_W-1:0] MODE_MUL = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_MODE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DEGREE_A = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DEGREE_B = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_ISSUE,
        ST_DRAIN,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic              valid;
        logic              last;
        logic              a_ok;
        logic              b_ok;
        logic [MODE_W-1:0] mode;
    } term_t;

    typedef struct packed {
        logic              we_a;
        logic              we_b;
        logic [AW-1:0]     addr;
        logic [COEF_W-1:0] data;
    } wr_t;

endpackage

// ===== hdl/pasm_ram.sv =====
// ----------------------------------------------------------------------------
// pasm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pasm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hdl/pasm_mac.sv =====
// ----------------------------------------------------------------------------
// pasm_mac
// Term pipeline: aligns with the RAM read, forms the product or the
// sum/difference of one coefficient pair, and accumulates it.
// ----------------------------------------------------------------------------
module pasm_mac (
    input  logic                              clk,
    input  logic                              rst_n,
    input  pasm_pkg::term_t                   term,
    input  logic                              acc_clr,
    input  logic signed [pasm_pkg::COEF_W-1:0] rd_a,
    input  logic signed [pasm_pkg::COEF_W-1:0] rd_b,
    output logic signed [pasm_pkg::ACC_W-1:0]  acc,
    output logic                              done
);

    localparam int PW = 2 * pasm_pkg::COEF_W;

    pasm_pkg::term_t                    t1_reg;
    logic                               v2_reg;
    logic                               last2_reg;
    logic signed [pasm_pkg::ACC_W-1:0]  val2_reg;
    logic signed [pasm_pkg::ACC_W-1:0]  val2_next;
    logic signed [pasm_pkg::ACC_W-1:0]  acc_reg;
    logic signed [pasm_pkg::ACC_W-1:0]  acc_next;
    logic signed [pasm_pkg::COEF_W-1:0] a;
    logic signed [pasm_pkg::COEF_W-1:0] b;
    logic signed [PW-1:0]               prod;
    logic signed [pasm_pkg::ACC_W-1:0]  a_ext;
    logic signed [pasm_pkg::ACC_W-1:0]  b_ext;

    always_comb
    begin
        a     = t1_reg.a_ok ? rd_a : '0;
        b     = t1_reg.b_ok ? rd_b : '0;
        prod  = a * b;
        a_ext = {{(pasm_pkg::ACC_W - pasm_pkg::COEF_W){a[pasm_pkg::COEF_W-1]}}, a};
        b_ext = {{(pasm_pkg::ACC_W - pasm_pkg::COEF_W){b[pasm_pkg::COEF_W-1]}}, b};
        unique case (t1_reg.mode)
            pasm_pkg::MODE_ADD: val2_next = a_ext + b_ext;
            pasm_pkg::MODE_SUB: val2_next = a_ext - b_ext;
            default:            val2_next = {{(pasm_pkg::ACC_W - PW){prod[PW-1]}}, prod};
        endcase
    end

    always_comb
    begin
        if (acc_clr)
        begin
            acc_next = '0;
        end
        else if (v2_reg)
        begin
            acc_next = acc_reg + val2_reg;
        end
        else
        begin
            acc_next = acc_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t1_reg    <= '0;
            v2_reg    <= 1'b0;
            last2_reg <= 1'b0;
        end
        else
        begin
            t1_reg    <= term;
            v2_reg    <= t1_reg.valid;
            last2_reg <= t1_reg.last;
        end
    end

    always_ff @(posedge clk)
    begin
        val2_reg <= val2_next;
        acc_reg  <= acc_next;
    end

    assign acc  = acc_reg;
    assign done = v2_reg && last2_reg;

endmodule

// ===== hdl/pasm_seq.sv =====
// ----------------------------------------------------------------------------
// pasm_seq
// Sequencer: configuration registers, coefficient loads, read address
// generation per result power, and the output beat register.
// ----------------------------------------------------------------------------
module pasm_seq (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [pasm_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [pasm_pkg::CFG_W-1:0]           cfg_data,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [pasm_pkg::OP_W-1:0]            s_op,
    input  logic [pasm_pkg::IN_POW_W-1:0]        s_power,
    input  logic [pasm_pkg::COEF_W-1:0]          s_coef,
    output pasm_pkg::wr_t                        wr,
    output logic [pasm_pkg::AW-1:0]              rd_addr_a,
    output logic [pasm_pkg::AW-1:0]              rd_addr_b,
    output pasm_pkg::term_t                      term,
    output logic                                 acc_clr,
    input  logic                                 done,
    input  logic signed [pasm_pkg::ACC_W-1:0]    acc,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [pasm_pkg::POW_W-1:0]           m_power,
    output logic [pasm_pkg::ACC_W-1:0]           m_coef,
    output logic                                 m_last
);

    localparam int PW = pasm_pkg::POW_W;

    pasm_pkg::state_t              state_reg;
    pasm_pkg::state_t              state_next;
    logic [pasm_pkg::MODE_W-1:0]   mode_reg;
    logic [pasm_pkg::DEG_W-1:0]    deg_a_reg;
    logic [pasm_pkg::DEG_W-1:0]    deg_b_reg;
    logic [PW-1:0]                 p_reg;
    logic [PW-1:0]                 p_next;
    logic [PW-1:0]                 i_reg;
    logic [PW-1:0]                 i_next;
    logic [PW-1:0]                 ihi_reg;
    logic [PW-1:0]                 ihi_next;
    logic                          m_tvalid_reg;
    logic [PW-1:0]                 m_power_reg;
    logic [pasm_pkg::ACC_W-1:0]    m_coef_reg;
    logic                          m_last_reg;

    logic [PW-1:0] da;
    logic [PW-1:0] db;
    logic [PW-1:0] top;
    logic [PW-1:0] i_lo;
    logic [PW-1:0] i_hi;
    logic [PW-1:0] j;
    logic          is_mul;
    logic          mode_ok;
    logic          accept;
    logic          go;
    logic          last_term;
    logic          out_free;
    logic          load_out;
    logic          p_last;

    always_comb
    begin
        da = (deg_a_reg > pasm_pkg::DEG_W'(pasm_pkg::MAX_DEGREE))
           ? PW'(pasm_pkg::MAX_DEGREE) : PW'(deg_a_reg);
        db = (deg_b_reg > pasm_pkg::DEG_W'(pasm_pkg::MAX_DEGREE))
           ? PW'(pasm_pkg::MAX_DEGREE) : PW'(deg_b_reg);
        is_mul  = (mode_reg == pasm_pkg::MODE_MUL);
        mode_ok = is_mul || (mode_reg == pasm_pkg::MODE_ADD) || (mode_reg == pasm_pkg::MODE_SUB);
        top     = is_mul ? (da + db) : ((da > db) ? da : db);
        i_lo    = (p_reg > db) ? (p_reg - db) : '0;
        i_hi    = (p_reg < da) ? p_reg : da;
        j       = is_mul ? (p_reg - i_reg) : p_reg;
        last_term = (i_reg == ihi_reg);
        out_free  = !m_tvalid_reg || m_tready;
        p_last    = (p_reg == top);
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            pasm_pkg::ST_IDLE:
            begin
                if (s_tvalid && (s_op == pasm_pkg::OP_COMPUTE) && mode_ok)
                begin
                    state_next = pasm_pkg::ST_START;
                end
            end
            pasm_pkg::ST_START: state_next = pasm_pkg::ST_ISSUE;
            pasm_pkg::ST_ISSUE:
            begin
                if (last_term)
                begin
                    state_next = pasm_pkg::ST_DRAIN;
                end
            end
            pasm_pkg::ST_DRAIN:
            begin
                if (done)
                begin
                    state_next = pasm_pkg::ST_EMIT;
                end
            end
            pasm_pkg::ST_EMIT:
            begin
                if (out_free)
                begin
                    state_next = p_last ? pasm_pkg::ST_IDLE : pasm_pkg::ST_START;
                end
            end
            default: state_next = pasm_pkg::ST_IDLE;
        endcase
    end

    // state outputs
    always_comb
    begin
        s_tready   = (state_reg == pasm_pkg::ST_IDLE);
        acc_clr    = (state_reg == pasm_pkg::ST_START);
        load_out   = (state_reg == pasm_pkg::ST_EMIT) && out_free;
        term.valid = (state_reg == pasm_pkg::ST_ISSUE);
        term.last  = last_term;
        term.a_ok  = (i_reg <= da);
        term.b_ok  = (j <= db);
        term.mode  = mode_reg;
    end

    assign accept = s_tvalid && s_tready;
    assign go     = accept && (s_op == pasm_pkg::OP_COMPUTE);

    always_comb
    begin
        wr.we_a = accept && (s_op == pasm_pkg::OP_LOAD_A)
               && (s_power <= pasm_pkg::IN_POW_W'(pasm_pkg::MAX_DEGREE));
        wr.we_b = accept && (s_op == pasm_pkg::OP_LOAD_B)
               && (s_power <= pasm_pkg::IN_POW_W'(pasm_pkg::MAX_DEGREE));
        wr.addr = s_power[pasm_pkg::AW-1:0];
        wr.data = s_coef;
    end

    assign rd_addr_a = i_reg[pasm_pkg::AW-1:0];
    assign rd_addr_b = j[pasm_pkg::AW-1:0];

    always_comb
    begin
        p_next   = p_reg;
        i_next   = i_reg;
        ihi_next = ihi_reg;
        if (go)
        begin
            p_next = '0;
        end
        else if (load_out && !p_last)
        begin
            p_next = p_reg + PW'(1);
        end
        if (state_reg == pasm_pkg::ST_START)
        begin
            i_next   = is_mul ? i_lo : p_reg;
            ihi_next = is_mul ? i_hi : p_reg;
        end
        else if (state_reg == pasm_pkg::ST_ISSUE)
        begin
            i_next = i_reg + PW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= pasm_pkg::ST_IDLE;
            mode_reg     <= '0;
            deg_a_reg    <= '0;
            deg_b_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    pasm_pkg::REG_MODE:     mode_reg  <= cfg_data[pasm_pkg::MODE_W-1:0];
                    pasm_pkg::REG_DEGREE_A: deg_a_reg <= cfg_data[pasm_pkg::DEG_W-1:0];
                    pasm_pkg::REG_DEGREE_B: deg_b_reg <= cfg_data[pasm_pkg::DEG_W-1:0];
                    default: ;
                endcase
            end
            if (load_out)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        p_reg   <= p_next;
        i_reg   <= i_next;
        ihi_reg <= ihi_next;
        if (load_out)
        begin
            m_power_reg <= p_reg;
            m_coef_reg  <= acc;
            m_last_reg  <= p_last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_power  = m_power_reg;
    assign m_coef   = m_coef_reg;
    assign m_last   = m_last_reg;

endmodule

// ===== hdl/polynomial_add_sub_mul.sv =====
// ----------------------------------------------------------------------------
// polynomial_add_sub_mul
// Two coefficient RAMs for A and B; on compute, emits A+B, A-B or A*B
// from power 0 upward with tlast on the highest power.
//
//   channel   dir  payload
//   s_axis    in   tuser: operation; tdata: power, coefficient
//   m_axis    out  tdata: result_power, result_coefficient; tlast: last
//   cfg       in   cfg_index 0 mode, 1 degree_a, 2 degree_b
//
// A load beat writes one coefficient; a compute beat holds off s_axis until
// done. Each result power issues one term per coefficient pair (one for
// add/sub), then drains the RAM read and the MAC pipeline before emit.
// Output waits in a register; m_axis stalls hold the sequencer in emit.
// Reset clears control and config; the RAMs are not cleared.
// ----------------------------------------------------------------------------
module polynomial_add_sub_mul (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [pasm_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [pasm_pkg::CFG_W-1:0]           cfg_data,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [23:0]                          s_axis_tdata,  // power, coefficient
    input  logic [pasm_pkg::OP_W-1:0]            s_axis_tuser,  // operation
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    output logic [47:0]                          m_axis_tdata,  // result_power, result_coefficient
    output logic                                 m_axis_tlast
);

    localparam int CW = pasm_pkg::COEF_W;
    localparam int PI = pasm_pkg::IN_POW_W;
    localparam int PO = pasm_pkg::POW_W;
    localparam int AC = pasm_pkg::ACC_W;

    pasm_pkg::wr_t                       wr;
    pasm_pkg::term_t                     term;
    logic [pasm_pkg::AW-1:0]             rd_addr_a;
    logic [pasm_pkg::AW-1:0]             rd_addr_b;
    logic [CW-1:0]                       rd_a;
    logic [CW-1:0]                       rd_b;
    logic                                acc_clr;
    logic                                done;
    logic signed [AC-1:0]                acc;
    logic [PO-1:0]                       m_power;
    logic [AC-1:0]                       m_coef;

    pasm_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_axis_tvalid),
        .s_tready  (s_axis_tready),
        .s_op      (s_axis_tuser),
        .s_power   (s_axis_tdata[PI-1:0]),
        .s_coef    (s_axis_tdata[PI+CW-1:PI]),
        .wr        (wr),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b),
        .term      (term),
        .acc_clr   (acc_clr),
        .done      (done),
        .acc       (acc),
        .m_tvalid  (m_axis_tvalid),
        .m_tready  (m_axis_tready),
        .m_power   (m_power),
        .m_coef    (m_coef),
        .m_last    (m_axis_tlast)
    );

    pasm_ram #(
        .WIDTH (CW),
        .DEPTH (pasm_pkg::DEPTH)
    ) u_ram_a (
        .clk   (clk),
        .we    (wr.we_a),
        .waddr (wr.addr),
        .wdata (wr.data),
        .raddr (rd_addr_a),
        .rdata (rd_a)
    );

    pasm_ram #(
        .WIDTH (CW),
        .DEPTH (pasm_pkg::DEPTH)
    ) u_ram_b (
        .clk   (clk),
        .we    (wr.we_b),
        .waddr (wr.addr),
        .wdata (wr.data),
        .raddr (rd_addr_b),
        .rdata (rd_b)
    );

    pasm_mac u_mac (
        .clk     (clk),
        .rst_n   (rst_n),
        .term    (term),
        .acc_clr (acc_clr),
        .rd_a    (rd_a),
        .rd_b    (rd_b),
        .acc     (acc),
        .done    (done)
    );

    assign m_axis_tdata = {{(48 - PO - AC){1'b0}}, m_coef, m_power};

endmodule
